// ===== design/header_field_value_parser_assert.svh =====
// assertion macros shared by the header field value parser
`ifndef HEADER_FIELD_VALUE_PARSER_ASSERT_SVH
`define HEADER_FIELD_VALUE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define HFVP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define HFVP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hfvp_pkg.sv =====
// types, constants and codes of the header field value parser
package hfvp_pkg;

	localparam int MAX_BLANK_RUN = 32;
	localparam int MAX_NEST      = 15;
	localparam int CNT_W  = $clog2(MAX_BLANK_RUN + 1);
	localparam int IDX_W  = $clog2(MAX_BLANK_RUN);
	localparam int NEST_W = $clog2(MAX_NEST + 1);

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [2:0] K_VALUE = 3'd0;
	localparam logic [2:0] K_NAME  = 3'd1;
	localparam logic [2:0] K_PVAL  = 3'd2;
	localparam logic [2:0] K_PEND  = 3'd3;
	localparam logic [2:0] K_DONE  = 3'd4;
	localparam logic [2:0] K_ERROR = 3'd5;

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_VALUE    = 4'd1,
		PH_VQUOTE   = 4'd2,
		PH_VQESC    = 4'd3,
		PH_VAFTERQ  = 4'd4,
		PH_COMMENT  = 4'd5,
		PH_PNAME    = 4'd6,
		PH_PNQUOTE  = 4'd7,
		PH_PNQESC   = 4'd8,
		PH_PNAFTERQ = 4'd9,
		PH_PVALUE   = 4'd10,
		PH_PVQUOTE  = 4'd11,
		PH_PVQESC   = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE  = 3'd0,
		C_FLUSH = 3'd1,
		C_BYTE  = 3'd2,
		C_PEND  = 3'd3,
		C_TERM  = 3'd4
	} ctl_state_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       is_final;
	} in_t;

	typedef struct packed {
		logic [2:0] out_kind;
		logic [7:0] out_byte;
		logic       run_end;
	} out_t;

	// which result groups one item produces
	typedef struct packed {
		logic flush;
		logic byte_v;
		logic pend;
		logic term;
	} plan_t;

	typedef struct packed {
		plan_t now;
		plan_t held;
		logic  flush_last;
	} dp_status_t;

	typedef struct packed {
		logic       load;
		logic       flush_step;
		ctl_state_t sel;
	} dp_cmd_t;

endpackage

// ===== design/hfvp_dp.sv =====
// datapath of the header field value parser: parse state, result plan, result mux
module hfvp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  hfvp_pkg::in_t       item,
	input  hfvp_pkg::dp_cmd_t   cmd,
	output hfvp_pkg::dp_status_t status,
	output hfvp_pkg::out_t      result
);
	import hfvp_pkg::*;

	phase_t             phase_q, n_phase;
	logic [MAX_BLANK_RUN-1:0] held_q, n_held;
	logic [CNT_W-1:0]   hcnt_q, n_hcnt;
	logic [NEST_W-1:0]  nest_q, n_nest, nest_dec;
	logic               vseen_q, n_vseen;
	logic               nseen_q, n_nseen;
	logic               pvseen_q, n_pvseen;
	logic               bpend_q, n_bpend;
	logic               err_q, n_err;

	logic [MAX_BLANK_RUN-1:0] fl_bits, fbits_q;
	logic [CNT_W-1:0]   fl_cnt, fcnt_q;
	logic               by_v, pe_v, te_v;
	logic [2:0]         by_k, te_k, byk_q, tek_q;
	logic [7:0]         byb_q;
	logic [IDX_W-1:0]   k_q;
	plan_t              plan_q, plan_c;
	logic               main_v;
	logic [7:0]         b;
	logic               blank;

	assign b     = item.byte_in;
	assign blank = (b == CH_SP) || (b == CH_TAB);

	always_comb begin
		n_phase  = phase_q;
		n_held   = held_q;
		n_hcnt   = hcnt_q;
		n_nest   = nest_q;
		n_vseen  = vseen_q;
		n_nseen  = nseen_q;
		n_pvseen = pvseen_q;
		n_bpend  = bpend_q;
		n_err    = err_q;
		fl_bits  = held_q;
		fl_cnt   = '0;
		by_v     = 1'b0;
		by_k     = K_VALUE;
		pe_v     = 1'b0;
		te_v     = 1'b0;
		te_k     = K_DONE;
		main_v   = 1'b0;
		nest_dec = (nest_q != '0) ? nest_q - NEST_W'(1) : '0;
		if (!err_q) begin
			case (phase_q)
				PH_START: begin
					if (b == CH_QUOTE) n_phase = PH_VQUOTE;
					else main_v = 1'b1;
				end
				PH_VALUE: main_v = 1'b1;
				PH_VQUOTE: begin
					if (b == CH_QUOTE) n_phase = PH_VAFTERQ;
					else if (b == CH_BSLASH) n_phase = PH_VQESC;
					else begin
						by_v = 1'b1;
						by_k = K_VALUE;
						n_vseen = 1'b1;
					end
				end
				PH_VQESC: begin
					by_v = 1'b1;
					by_k = K_VALUE;
					n_vseen = 1'b1;
					n_phase = PH_VQUOTE;
				end
				PH_VAFTERQ: begin
					if (!blank) begin
						if (b == CH_SEMI && vseen_q) begin
							n_phase = PH_PNAME;
							n_nseen = 1'b0;
							n_pvseen = 1'b0;
							n_bpend = 1'b0;
						end else n_err = 1'b1;
					end
				end
				PH_COMMENT: begin
					if (b == CH_LPAR) begin
						if (nest_q >= NEST_W'(MAX_NEST)) n_err = 1'b1;
						else n_nest = nest_q + NEST_W'(1);
					end else if (b == CH_RPAR) begin
						n_nest = nest_dec;
						if (nest_dec == '0) n_phase = PH_VALUE;
					end
				end
				PH_PNAME: begin
					if (blank) begin
						if (nseen_q) n_err = 1'b1;
					end else if (b == CH_QUOTE) begin
						if (nseen_q) n_err = 1'b1;
						else n_phase = PH_PNQUOTE;
					end else if (b == CH_EQ) begin
						if (!nseen_q) n_err = 1'b1;
						else begin
							n_phase = PH_PVALUE;
							n_pvseen = 1'b0;
							n_bpend = 1'b0;
						end
					end else if (b == CH_SEMI) begin
						n_err = 1'b1;
					end else begin
						by_v = 1'b1;
						by_k = K_NAME;
						n_nseen = 1'b1;
					end
				end
				PH_PNQUOTE: begin
					if (b == CH_QUOTE) n_phase = PH_PNAFTERQ;
					else if (b == CH_BSLASH) n_phase = PH_PNQESC;
					else begin
						by_v = 1'b1;
						by_k = K_NAME;
						n_nseen = 1'b1;
					end
				end
				PH_PNQESC: begin
					by_v = 1'b1;
					by_k = K_NAME;
					n_nseen = 1'b1;
					n_phase = PH_PNQUOTE;
				end
				PH_PNAFTERQ: begin
					if (b == CH_EQ && nseen_q) begin
						n_phase = PH_PVALUE;
						n_pvseen = 1'b0;
						n_bpend = 1'b0;
					end else n_err = 1'b1;
				end
				PH_PVALUE: begin
					if (blank) begin
						if (pvseen_q) n_bpend = 1'b1;
						else n_err = 1'b1;
					end else if (b == CH_SEMI) begin
						if (pvseen_q) begin
							pe_v = 1'b1;
							n_phase = PH_PNAME;
							n_nseen = 1'b0;
							n_pvseen = 1'b0;
							n_bpend = 1'b0;
						end else n_err = 1'b1;
					end else if (bpend_q || b == CH_EQ) begin
						n_err = 1'b1;
					end else if (b == CH_QUOTE) begin
						if (pvseen_q) n_err = 1'b1;
						else n_phase = PH_PVQUOTE;
					end else begin
						by_v = 1'b1;
						by_k = K_PVAL;
						n_pvseen = 1'b1;
					end
				end
				PH_PVQUOTE: begin
					if (b == CH_QUOTE) begin
						n_phase = PH_PVALUE;
						n_bpend = 1'b1;
					end else if (b == CH_BSLASH) n_phase = PH_PVQESC;
					else begin
						by_v = 1'b1;
						by_k = K_PVAL;
						n_pvseen = 1'b1;
					end
				end
				PH_PVQESC: begin
					by_v = 1'b1;
					by_k = K_PVAL;
					n_pvseen = 1'b1;
					n_phase = PH_PVQUOTE;
				end
				default: n_err = 1'b1;
			endcase

			// unquoted main value byte
			if (main_v) begin
				n_phase = PH_VALUE;
				if (blank) begin
					if (hcnt_q >= CNT_W'(MAX_BLANK_RUN)) n_err = 1'b1;
					else begin
						if (b == CH_TAB) n_held[hcnt_q[IDX_W-1:0]] = 1'b1;
						n_hcnt = hcnt_q + CNT_W'(1);
					end
				end else if (b == CH_SEMI) begin
					n_held = '0;
					n_hcnt = '0;
					if (!vseen_q) n_err = 1'b1;
					else begin
						n_phase = PH_PNAME;
						n_nseen = 1'b0;
						n_pvseen = 1'b0;
						n_bpend = 1'b0;
					end
				end else begin
					if (hcnt_q != '0) begin
						fl_bits = held_q;
						fl_cnt = hcnt_q;
						n_vseen = 1'b1;
					end
					n_held = '0;
					n_hcnt = '0;
					if (b == CH_CR || b == CH_LF || b == CH_NUL || b == CH_QUOTE) begin
						n_err = 1'b1;
					end else if (b == CH_LPAR) begin
						n_phase = PH_COMMENT;
						n_nest = NEST_W'(1);
					end else begin
						by_v = 1'b1;
						by_k = K_VALUE;
						n_vseen = 1'b1;
					end
				end
			end
		end

		// end of string: closing results, then back to the reset state
		if (item.is_final) begin
			if (!n_err) begin
				case (n_phase) inside
					PH_START, PH_VALUE: begin
						if (n_hcnt != '0) begin
							fl_bits = n_held;
							fl_cnt = n_hcnt;
						end
						te_v = 1'b1;
						te_k = K_DONE;
					end
					PH_VAFTERQ: begin
						te_v = 1'b1;
						te_k = K_DONE;
					end
					PH_PVALUE: begin
						if (n_pvseen) begin
							pe_v = 1'b1;
							te_v = 1'b1;
							te_k = K_DONE;
						end else n_err = 1'b1;
					end
					default: n_err = 1'b1;
				endcase
			end
			if (n_err) begin
				te_v = 1'b1;
				te_k = K_ERROR;
			end
			n_phase  = PH_START;
			n_held   = '0;
			n_hcnt   = '0;
			n_nest   = '0;
			n_vseen  = 1'b0;
			n_nseen  = 1'b0;
			n_pvseen = 1'b0;
			n_bpend  = 1'b0;
			n_err    = 1'b0;
		end
	end

	assign plan_c.flush  = (fl_cnt != '0);
	assign plan_c.byte_v = by_v;
	assign plan_c.pend   = pe_v;
	assign plan_c.term   = te_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			held_q   <= '0;
			hcnt_q   <= '0;
			nest_q   <= '0;
			vseen_q  <= 1'b0;
			nseen_q  <= 1'b0;
			pvseen_q <= 1'b0;
			bpend_q  <= 1'b0;
			err_q    <= 1'b0;
			plan_q   <= '0;
			fcnt_q   <= '0;
			k_q      <= '0;
		end else if (cmd.load) begin
			phase_q  <= n_phase;
			held_q   <= n_held;
			hcnt_q   <= n_hcnt;
			nest_q   <= n_nest;
			vseen_q  <= n_vseen;
			nseen_q  <= n_nseen;
			pvseen_q <= n_pvseen;
			bpend_q  <= n_bpend;
			err_q    <= n_err;
			plan_q   <= plan_c;
			fcnt_q   <= fl_cnt;
			k_q      <= '0;
		end else if (cmd.flush_step) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fbits_q <= fl_bits;
			byk_q   <= by_k;
			byb_q   <= b;
			tek_q   <= te_k;
		end
	end

	assign status.now        = plan_c;
	assign status.held       = plan_q;
	assign status.flush_last = ((CNT_W'(k_q) + CNT_W'(1)) == fcnt_q);

	always_comb begin
		result = '0;
		unique case (cmd.sel)
			C_IDLE: result = '0;
			C_FLUSH: begin
				result.out_kind = K_VALUE;
				result.out_byte = fbits_q[k_q] ? CH_TAB : CH_SP;
			end
			C_BYTE: begin
				result.out_kind = byk_q;
				result.out_byte = byb_q;
			end
			C_PEND: result.out_kind = K_PEND;
			C_TERM: begin
				result.out_kind = tek_q;
				result.run_end = 1'b1;
			end
			default: result = '0;
		endcase
	end

endmodule

// ===== design/hfvp_ctrl.sv =====
// controller of the header field value parser: sequences the results of one item
module hfvp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  hfvp_pkg::dp_status_t status,
	output hfvp_pkg::dp_cmd_t    cmd
);
	import hfvp_pkg::*;

	ctl_state_t state_q, state_d;
	logic       xfer;
	logic       last;
	logic       load;

	// first result group after stage st that the plan holds
	function automatic ctl_state_t next_after(plan_t p, ctl_state_t st);
		ctl_state_t nx;
		nx = C_IDLE;
		if (p.term && st < C_TERM) nx = C_TERM;
		if (p.pend && st < C_PEND) nx = C_PEND;
		if (p.byte_v && st < C_BYTE) nx = C_BYTE;
		if (p.flush && st < C_FLUSH) nx = C_FLUSH;
		return nx;
	endfunction

	assign xfer = (state_q != C_IDLE) && result_ready;
	assign last = (next_after(status.held, state_q) == C_IDLE) &&
		!(state_q == C_FLUSH && !status.flush_last);
	assign load = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		if (load) begin
			state_d = next_after(status.now, C_IDLE);
		end else if (xfer) begin
			if (!(state_q == C_FLUSH && !status.flush_last))
				state_d = next_after(status.held, state_q);
		end
	end

	always_comb begin
		item_ready     = (state_q == C_IDLE) || (xfer && last);
		result_valid   = (state_q != C_IDLE);
		cmd.load       = item_valid && ((state_q == C_IDLE) || (xfer && last));
		cmd.flush_step = xfer && (state_q == C_FLUSH);
		cmd.sel        = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/header_field_value_parser.sv =====
// Header field value parser. Takes one byte of a header field value per transfer
// and tags it as main value, parameter name or parameter value byte, with a
// parameter end after each name=value pair and one done or error result, with
// run_end set, on the byte marked is_final; after that the block is back in its
// reset state. Blanks in the main value are held back and come out just before
// the next byte that is not a blank or ';' and before the closing result, or are
// dropped before ';'. Comments in parentheses are dropped. Results leave one per
// cycle from the result sequencer while result_ready is high; an item that gives
// no result leaves it idle, and the next item is taken in the cycle in which the
// last result of the current one transfers.
module header_field_value_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  hfvp_pkg::in_t   item,
	output logic            result_valid,
	input  logic            result_ready,
	output hfvp_pkg::out_t  result
);
	import hfvp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	hfvp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	hfvp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

`include "header_field_value_parser_assert.svh"

	// only the closing result of a string carries run_end
	`HFVP_ASSERT_NOW(a_run_end_kind, result_valid && result.run_end, result.out_kind == K_DONE || result.out_kind == K_ERROR, "run_end on a result that is not done or error")
	// a new item while results are pending only on the transfer of the last one
	`HFVP_ASSERT_NOW(a_accept_on_drain, item_valid && item_ready && result_valid, result_ready, "item taken while a result is stalled")
	// the closing result frees the input side
	`HFVP_ASSERT_NOW(a_ready_after_end, result_valid && result_ready && result.run_end, item_ready, "not ready on the closing result transfer")
	// nothing follows the closing result until a new item arrives
	`HFVP_ASSERT_NEXT(a_quiet_after_end, result_valid && result_ready && result.run_end && !item_valid, !result_valid, "result after the closing result with no new item")

endmodule

// ===== tb/sv/header_field_value_parser_test.sv =====
// testbench for the header field value parser: random field strings checked against a tag model
module header_field_value_parser_test;
	import hfvp_pkg::*;

	// expected tag stream of the parser, built byte by byte as inputs transfer
	class tag_book;
		phase_t                   ph;
		logic [MAX_BLANK_RUN-1:0] blank_tabs;
		int                       blank_cnt;
		int                       nest;
		bit                       got_value;
		bit                       got_name;
		bit                       got_pval;
		bit                       blank_after;
		bit                       broken;
		out_t                     due_tags[$];
		int                       mismatches;

		function new();
			clear();
		endfunction

		function void clear();
			ph = PH_START;
			blank_tabs = '0;
			blank_cnt = 0;
			nest = 0;
			got_value = 0;
			got_name = 0;
			got_pval = 0;
			blank_after = 0;
			broken = 0;
		endfunction

		function bit blank(logic [7:0] b);
			return b == CH_SP || b == CH_TAB;
		endfunction

		function void push_tag(logic [2:0] kind, logic [7:0] b, logic last);
			out_t t;
			t.out_kind = kind;
			t.out_byte = b;
			t.run_end = last;
			due_tags.insert(due_tags.size(), t);
		endfunction

		function void flush_held();
			for (int k = 0; k < blank_cnt; k++) begin
				push_tag(K_VALUE, blank_tabs[k] ? CH_TAB : CH_SP, 1'b0);
				got_value = 1;
			end
			blank_tabs = '0;
			blank_cnt = 0;
		endfunction

		function void open_params();
			ph = PH_PNAME;
			got_name = 0;
			got_pval = 0;
			blank_after = 0;
		endfunction

		function void value_byte(logic [7:0] b);
			ph = PH_VALUE;
			if (blank(b)) begin
				if (blank_cnt >= MAX_BLANK_RUN) begin
					broken = 1;
				end else begin
					if (b == CH_TAB)
						blank_tabs[blank_cnt] = 1'b1;
					blank_cnt++;
				end
			end else if (b == CH_SEMI) begin
				// held blanks before ';' are dropped
				blank_tabs = '0;
				blank_cnt = 0;
				if (!got_value)
					broken = 1;
				else
					open_params();
			end else begin
				flush_held();
				if (b == CH_CR || b == CH_LF || b == CH_NUL || b == CH_QUOTE) begin
					broken = 1;
				end else if (b == CH_LPAR) begin
					ph = PH_COMMENT;
					nest = 1;
				end else begin
					push_tag(K_VALUE, b, 1'b0);
					got_value = 1;
				end
			end
		endfunction

		function void take_byte(in_t it);
			logic [7:0] b;
			b = it.byte_in;
			if (!broken) begin
				case (ph)
					PH_START: begin
						if (b == CH_QUOTE)
							ph = PH_VQUOTE;
						else
							value_byte(b);
					end
					PH_VALUE: value_byte(b);
					PH_VQUOTE: begin
						if (b == CH_QUOTE) begin
							ph = PH_VAFTERQ;
						end else if (b == CH_BSLASH) begin
							ph = PH_VQESC;
						end else begin
							push_tag(K_VALUE, b, 1'b0);
							got_value = 1;
						end
					end
					PH_VQESC: begin
						push_tag(K_VALUE, b, 1'b0);
						got_value = 1;
						ph = PH_VQUOTE;
					end
					PH_VAFTERQ: begin
						if (!blank(b)) begin
							if (b == CH_SEMI && got_value)
								open_params();
							else
								broken = 1;
						end
					end
					PH_COMMENT: begin
						if (b == CH_LPAR) begin
							if (nest >= MAX_NEST)
								broken = 1;
							else
								nest++;
						end else if (b == CH_RPAR) begin
							if (nest > 0)
								nest--;
							if (nest == 0)
								ph = PH_VALUE;
						end
					end
					PH_PNAME: begin
						if (blank(b)) begin
							if (got_name)
								broken = 1;
						end else if (b == CH_QUOTE) begin
							if (got_name)
								broken = 1;
							else
								ph = PH_PNQUOTE;
						end else if (b == CH_EQ) begin
							if (!got_name) begin
								broken = 1;
							end else begin
								ph = PH_PVALUE;
								got_pval = 0;
								blank_after = 0;
							end
						end else if (b == CH_SEMI) begin
							broken = 1;
						end else begin
							push_tag(K_NAME, b, 1'b0);
							got_name = 1;
						end
					end
					PH_PNQUOTE: begin
						if (b == CH_QUOTE) begin
							ph = PH_PNAFTERQ;
						end else if (b == CH_BSLASH) begin
							ph = PH_PNQESC;
						end else begin
							push_tag(K_NAME, b, 1'b0);
							got_name = 1;
						end
					end
					PH_PNQESC: begin
						push_tag(K_NAME, b, 1'b0);
						got_name = 1;
						ph = PH_PNQUOTE;
					end
					PH_PNAFTERQ: begin
						if (b == CH_EQ && got_name) begin
							ph = PH_PVALUE;
							got_pval = 0;
							blank_after = 0;
						end else begin
							broken = 1;
						end
					end
					PH_PVALUE: begin
						if (blank(b)) begin
							if (got_pval)
								blank_after = 1;
							else
								broken = 1;
						end else if (b == CH_SEMI) begin
							if (got_pval) begin
								push_tag(K_PEND, 8'h00, 1'b0);
								open_params();
							end else begin
								broken = 1;
							end
						end else if (blank_after || b == CH_EQ) begin
							broken = 1;
						end else if (b == CH_QUOTE) begin
							if (got_pval)
								broken = 1;
							else
								ph = PH_PVQUOTE;
						end else begin
							push_tag(K_PVAL, b, 1'b0);
							got_pval = 1;
						end
					end
					PH_PVQUOTE: begin
						if (b == CH_QUOTE) begin
							// closing quote: only blanks, ';' or the end may follow
							ph = PH_PVALUE;
							blank_after = 1;
						end else if (b == CH_BSLASH) begin
							ph = PH_PVQESC;
						end else begin
							push_tag(K_PVAL, b, 1'b0);
							got_pval = 1;
						end
					end
					PH_PVQESC: begin
						push_tag(K_PVAL, b, 1'b0);
						got_pval = 1;
						ph = PH_PVQUOTE;
					end
					default: broken = 1;
				endcase
			end
			if (it.is_final) begin
				if (!broken) begin
					case (ph)
						PH_START, PH_VALUE: begin
							flush_held();
							push_tag(K_DONE, 8'h00, 1'b1);
						end
						PH_VAFTERQ: push_tag(K_DONE, 8'h00, 1'b1);
						PH_PVALUE: begin
							if (got_pval) begin
								push_tag(K_PEND, 8'h00, 1'b0);
								push_tag(K_DONE, 8'h00, 1'b1);
							end else begin
								broken = 1;
							end
						end
						default: broken = 1;
					endcase
				end
				if (broken)
					push_tag(K_ERROR, 8'h00, 1'b1);
				clear();
			end
		endfunction

		function void miss(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void compare_tag(out_t got);
			out_t want;
			if (due_tags.size() == 0) begin
				miss($sformatf("unexpected tag: kind %0d byte %02h end %0d",
					got.out_kind, got.out_byte, got.run_end));
			end else begin
				want = due_tags.pop_front();
				if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
					got.run_end !== want.run_end)
					miss($sformatf({"tag mismatch: expected kind %0d byte %02h end %0d,",
						" got kind %0d byte %02h end %0d"},
						want.out_kind, want.out_byte, want.run_end,
						got.out_kind, got.out_byte, got.run_end));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_t  item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic [7:0]  text[$];
	tag_book     book = new();

	function automatic void append_char(logic [7:0] c);
		text.insert(text.size(), c);
	endfunction

	header_field_value_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			book.compare_tag(result);
		if (arst_n && item_valid && item_ready)
			book.take_byte(item);
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#3200000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{byte_in: b, is_final: last};
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	function automatic void load_text(string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endfunction

	function automatic logic [7:0] plain_char();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 8'h61 + 8'($urandom_range(25));
		else if (r < 85)
			return 8'h30 + 8'($urandom_range(9));
		else
			return 8'h80 + 8'($urandom_range(127));
	endfunction

	// anything at all, leaning on the bytes the parser treats specially
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return plain_char();
		if (r < 70)
			return 8'($urandom_range(255));
		case ($urandom_range(10))
			0: return CH_SEMI;
			1: return CH_EQ;
			2: return CH_QUOTE;
			3: return CH_BSLASH;
			4: return CH_LPAR;
			5: return CH_RPAR;
			6: return CH_SP;
			7: return CH_TAB;
			8: return CH_CR;
			9: return CH_LF;
			default: return CH_NUL;
		endcase
	endfunction

	function automatic void push_blanks(int n);
		for (int k = 0; k < n; k++)
			append_char($urandom_range(1) ? CH_TAB : CH_SP);
	endfunction

	function automatic void push_token(int n);
		for (int k = 0; k < n; k++)
			append_char(plain_char());
	endfunction

	function automatic void push_quoted(int n);
		int r;
		append_char(CH_QUOTE);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(9);
			if (r < 2) begin
				append_char(CH_BSLASH);
				append_char(8'($urandom_range(255)));
			end else if (r < 4) begin
				case ($urandom_range(4))
					0: append_char(CH_SEMI);
					1: append_char(CH_SP);
					2: append_char(CH_LPAR);
					3: append_char(CH_EQ);
					default: append_char(CH_TAB);
				endcase
			end else begin
				append_char(plain_char());
			end
		end
		append_char(CH_QUOTE);
	endfunction

	function automatic void push_comment(int depth);
		for (int k = 0; k < depth; k++) begin
			append_char(CH_LPAR);
			if ($urandom_range(1))
				append_char(plain_char());
		end
		for (int k = 0; k < depth; k++)
			append_char(CH_RPAR);
	endfunction

	// mostly well-formed field values; about a third get a byte replaced, a byte inserted, the tail cut or a ';' appended
	function automatic void build_string();
		int r;
		int n;
		text.delete();
		if ($urandom_range(3) == 0) begin
			push_quoted($urandom_range(4));
			if ($urandom_range(1))
				push_blanks($urandom_range(1, 2));
		end else begin
			n = $urandom_range(1, 3);
			if ($urandom_range(5) == 0)
				push_blanks($urandom_range(1, 2));
			for (int k = 0; k < n; k++) begin
				push_token($urandom_range(1, 4));
				if (k < n - 1 || $urandom_range(3) == 0) begin
					r = $urandom_range(19);
					if (r == 0)
						push_blanks($urandom_range(30, 33));
					else if (r == 1)
						push_comment($urandom_range(14, 16));
					else if (r < 10)
						push_blanks($urandom_range(1, 2));
					else
						push_comment($urandom_range(1, 2));
				end
			end
		end
		n = $urandom_range(2);
		for (int k = 0; k < n; k++) begin
			append_char(CH_SEMI);
			if ($urandom_range(3) == 0)
				push_blanks(1);
			if ($urandom_range(3) == 0)
				push_quoted($urandom_range(1, 3));
			else
				push_token($urandom_range(1, 3));
			append_char(CH_EQ);
			if ($urandom_range(3) == 0)
				push_quoted($urandom_range(1, 3));
			else
				push_token($urandom_range(1, 3));
			if ($urandom_range(3) == 0)
				push_blanks(1);
		end
		case ($urandom_range(11))
			0: text[$urandom_range(text.size() - 1)] = pick_char();
			1: text.insert($urandom_range(text.size() - 1), pick_char());
			2: begin
				n = $urandom_range(1, text.size());
				while (text.size() > n)
					text.pop_back();
			end
			3: append_char(CH_SEMI);
			default: ;
		endcase
	endfunction

	initial begin
		int sent;
		int w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// hand-picked strings: byte extremes, escaped quote, comments, params, empty value
		text = '{CH_NUL};
		send_text();
		text = '{8'hFF};
		send_text();
		load_text("\"a\\\"\";x=1");
		send_text();
		load_text("a\t(())x ;p=v");
		send_text();
		load_text(";");
		send_text();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 45; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 45; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			sent = 0;
			while (sent < 22) begin
				build_string();
				sent += text.size();
				send_text();
			end
		end
		item_valid <= 1'b0;

		for (w = 0; w < 20000 && book.due_tags.size() != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (book.due_tags.size() != 0)
			book.miss($sformatf("%0d tags never arrived", book.due_tags.size()));
		if (book.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
